[src/pqet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqet_pkg
// Shared types, channel codes and result codes of the power-quality event
// trigger.
// ----------------------------------------------------------------------------
package pqet_pkg;

    localparam int NUM_CH    = 6;
    localparam int CH_W      = 3;
    localparam int VAL_W     = 32;
    localparam int SEV_W     = 20;
    localparam int KIND_W    = 3;
    localparam int DETAIL_W  = 4;
    localparam int PHASE_W   = 2;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = 20;

    localparam logic [SEV_W-1:0]        Q_TEN   = 20'd655360;
    localparam logic signed [VAL_W-1:0] Q_TEN_S = 32'sd655360;

    localparam logic [CH_W-1:0] CH_VDEV = 3'd0;
    localparam logic [CH_W-1:0] CH_VTHD = 3'd1;
    localparam logic [CH_W-1:0] CH_ITHD = 3'd2;
    localparam logic [CH_W-1:0] CH_UNBL = 3'd3;
    localparam logic [CH_W-1:0] CH_FREQ = 3'd4;
    localparam logic [CH_W-1:0] CH_XFMR = 3'd5;

    localparam logic [KIND_W-1:0] KIND_SAG       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SWELL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HARMONIC  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNBALANCE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERLOAD  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FREQ      = 3'd5;

    localparam logic [DETAIL_W-1:0] DET_SAG       = 4'd0;
    localparam logic [DETAIL_W-1:0] DET_DEVIATION = 4'd1;
    localparam logic [DETAIL_W-1:0] DET_SWELL     = 4'd2;
    localparam logic [DETAIL_W-1:0] DET_VTHD      = 4'd3;
    localparam logic [DETAIL_W-1:0] DET_ITHD      = 4'd4;
    localparam logic [DETAIL_W-1:0] DET_UNBALANCE = 4'd5;
    localparam logic [DETAIL_W-1:0] DET_FREQ      = 4'd6;
    localparam logic [DETAIL_W-1:0] DET_OVERLOAD  = 4'd7;
    localparam logic [DETAIL_W-1:0] DET_LOAD_WARN = 4'd8;

    typedef struct packed {
        logic            load;
        logic            chk;
        logic [CH_W-1:0] ch;
        logic            prep;
        logic            div_step;
        logic            publish;
    } dp_cmd_t;

    typedef struct packed {
        logic fire;
        logic div_skip;
        logic out_free;
    } dp_status_t;

    function automatic logic [KIND_W-1:0] chan_kind(input logic [CH_W-1:0] ch);
        logic [KIND_W-1:0] k;
        case (ch)
            CH_VDEV: k = KIND_SWELL;
            CH_VTHD: k = KIND_HARMONIC;
            CH_ITHD: k = KIND_HARMONIC;
            CH_UNBL: k = KIND_UNBALANCE;
            CH_FREQ: k = KIND_FREQ;
            CH_XFMR: k = KIND_OVERLOAD;
            default: k = KIND_SAG;
        endcase
        return k;
    endfunction

    function automatic logic [DETAIL_W-1:0] chan_detail(input logic [CH_W-1:0] ch);
        logic [DETAIL_W-1:0] d;
        case (ch)
            CH_VDEV: d = DET_DEVIATION;
            CH_VTHD: d = DET_VTHD;
            CH_ITHD: d = DET_ITHD;
            CH_UNBL: d = DET_UNBALANCE;
            CH_FREQ: d = DET_FREQ;
            CH_XFMR: d = DET_OVERLOAD;
            default: d = DET_SAG;
        endcase
        return d;
    endfunction

endpackage

[src/pqet_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqet_ctrl
// Sequencer: accepts a snapshot, walks the channels one per cycle, runs the
// severity divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module pqet_ctrl
    import pqet_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.ch       = ch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    ch_next    = CH_VDEV;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.chk = 1'b1;
                if (st.fire) begin
                    state_next = ST_PREP;
                end else if (ch_reg == CH_XFMR) begin
                    state_next = ST_DONE;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                cnt_next = CNT_W'(DIV_STEPS - 1);
                if (st.div_skip) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (st.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_VDEV;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[src/pqet_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqet_dp
// Datapath: limit registers, snapshot registers, shared threshold comparator,
// alarm flags, restoring severity divider and output register.
// ----------------------------------------------------------------------------
module pqet_dp
    import pqet_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 st,
    input  logic                       cfg_we,
    input  logic [CH_W-1:0]            cfg_index,
    input  logic [VAL_W-1:0]           cfg_data,
    input  logic signed [VAL_W-1:0]    in_val [NUM_CH],
    input  logic [PHASE_W-1:0]         in_phase,
    input  logic [VAL_W-1:0]           in_time,
    input  logic                       m_tready,
    output logic                       out_valid,
    output logic                       out_triggered,
    output logic [VAL_W-1:0]           out_event_id,
    output logic [KIND_W-1:0]          out_kind,
    output logic [DETAIL_W-1:0]        out_detail,
    output logic [SEV_W-1:0]           out_severity,
    output logic signed [VAL_W-1:0]    out_value,
    output logic signed [VAL_W-1:0]    out_limit,
    output logic [PHASE_W-1:0]         out_phase,
    output logic [VAL_W-1:0]           out_time
);

    logic signed [VAL_W-1:0] limit_reg [NUM_CH];
    logic signed [VAL_W-1:0] val_reg   [NUM_CH];
    logic [PHASE_W-1:0]      phase_reg;
    logic [VAL_W-1:0]        time_reg;
    logic [NUM_CH-1:0]       flags_reg;
    logic [VAL_W-1:0]        next_id_reg;

    logic                    fired_reg;
    logic signed [VAL_W-1:0] sel_val_reg, sel_lim_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [DETAIL_W-1:0]     detail_reg;
    logic [VAL_W-1:0]        rem_reg;
    logic [DIV_STEPS-1:0]    dbits_reg;
    logic [SEV_W-1:0]        q_reg;

    logic                    ovalid_reg;
    logic                    otrig_reg;
    logic [VAL_W-1:0]        oid_reg;
    logic [KIND_W-1:0]       okind_reg;
    logic [DETAIL_W-1:0]     odet_reg;
    logic [SEV_W-1:0]        osev_reg;
    logic signed [VAL_W-1:0] oval_reg, olim_reg;
    logic [PHASE_W-1:0]      ophase_reg;
    logic [VAL_W-1:0]        otime_reg;

    // channel check
    logic signed [VAL_W-1:0] cv, cl;
    logic [VAL_W:0]          cmag;
    logic signed [VAL_W+1:0] cx;
    logic signed [39:0]      x40, l40, ten_x, nine_l, tf_x, tt_l;
    logic                    enter, exitb, sag, swell, gt, flag_cur;
    logic                    fire, flag_new;
    logic [KIND_W-1:0]       fire_kind;
    logic [DETAIL_W-1:0]     fire_detail;

    always_comb begin
        case (cmd.ch)
            CH_VDEV: begin cv = val_reg[0]; cl = limit_reg[0]; end
            CH_VTHD: begin cv = val_reg[1]; cl = limit_reg[1]; end
            CH_ITHD: begin cv = val_reg[2]; cl = limit_reg[2]; end
            CH_UNBL: begin cv = val_reg[3]; cl = limit_reg[3]; end
            CH_FREQ: begin cv = val_reg[4]; cl = limit_reg[4]; end
            CH_XFMR: begin cv = val_reg[5]; cl = limit_reg[5]; end
            default: begin cv = '0; cl = '0; end
        endcase
    end

    assign cmag   = cv[VAL_W-1] ? ((VAL_W+1)'(0) - {cv[VAL_W-1], cv}) : {1'b0, cv};
    assign cx     = (cmd.ch == CH_VDEV) ? $signed({1'b0, cmag})
                                        : $signed({{2{cv[VAL_W-1]}}, cv});
    assign x40    = $signed({{6{cx[VAL_W+1]}}, cx});
    assign l40    = $signed({{8{cl[VAL_W-1]}}, cl});
    assign ten_x  = (x40 <<< 3) + (x40 <<< 1);
    assign nine_l = (l40 <<< 3) + l40;
    assign tf_x   = (x40 <<< 4) + (x40 <<< 3) + x40;
    assign tt_l   = (l40 <<< 4) + (l40 <<< 2) + (l40 <<< 1) + l40;
    assign enter  = ten_x > nine_l;
    assign exitb  = tf_x < tt_l;
    assign sag    = cv < -Q_TEN_S;
    assign swell  = cv > Q_TEN_S;
    assign gt     = cv > cl;
    assign flag_cur = flags_reg[cmd.ch];

    always_comb begin
        fire        = 1'b0;
        flag_new    = flag_cur;
        fire_kind   = chan_kind(cmd.ch);
        fire_detail = chan_detail(cmd.ch);
        if (cmd.ch == CH_VDEV) begin
            if (sag || enter || swell) begin
                fire     = 1'b1;
                flag_new = 1'b1;
            end else if (exitb) begin
                flag_new = 1'b0;
            end
            if (sag) begin
                fire_kind   = KIND_SAG;
                fire_detail = DET_SAG;
            end else if (!enter) begin
                fire_detail = DET_SWELL;
            end
        end else begin
            if (enter) begin
                fire     = 1'b1;
                flag_new = 1'b1;
            end else if (flag_cur) begin
                if (exitb) begin
                    flag_new = 1'b0;
                end else begin
                    fire = 1'b1;
                end
            end
            if (cmd.ch == CH_XFMR && !gt) begin
                fire_detail = DET_LOAD_WARN;
            end
        end
    end

    // divider setup and step
    logic [VAL_W-1:0] pmag;
    logic [35:0]      ten_lim;
    logic             lim_pos, sat;
    logic [VAL_W:0]   dtrial, ddiff;
    logic             dge;

    assign pmag    = sel_val_reg[VAL_W-1] ? VAL_W'(-sel_val_reg) : VAL_W'(sel_val_reg);
    assign ten_lim = ({4'b0, sel_lim_reg} << 3) + ({4'b0, sel_lim_reg} << 1);
    assign lim_pos = !sel_lim_reg[VAL_W-1] && (sel_lim_reg != '0);
    assign sat     = {4'b0, pmag} >= ten_lim;
    assign dtrial  = {rem_reg, dbits_reg[DIV_STEPS-1]};
    assign dge     = dtrial >= {1'b0, sel_lim_reg};
    assign ddiff   = dtrial - {1'b0, sel_lim_reg};

    assign st.fire     = fire;
    assign st.div_skip = !lim_pos || sat;
    assign st.out_free = !ovalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                limit_reg[i] <= '0;
            end
            flags_reg   <= '0;
            next_id_reg <= VAL_W'(1);
            fired_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index < CH_W'(NUM_CH)) begin
                limit_reg[cfg_index] <= cfg_data;
            end
            if (cmd.load) begin
                fired_reg <= 1'b0;
            end
            if (cmd.chk) begin
                flags_reg[cmd.ch] <= flag_new;
                if (fire) begin
                    fired_reg <= 1'b1;
                end
            end
            if (cmd.publish) begin
                ovalid_reg <= 1'b1;
                if (fired_reg) begin
                    next_id_reg <= next_id_reg + 1'b1;
                end
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < NUM_CH; i++) begin
                val_reg[i] <= in_val[i];
            end
            phase_reg <= in_phase;
            time_reg  <= in_time;
        end
        if (cmd.chk && fire) begin
            sel_val_reg <= cv;
            sel_lim_reg <= cl;
            kind_reg    <= fire_kind;
            detail_reg  <= fire_detail;
        end
        if (cmd.prep) begin
            rem_reg   <= VAL_W'(pmag >> 4);
            dbits_reg <= {pmag[3:0], 16'b0};
            if (!lim_pos) begin
                q_reg <= '0;
            end else if (sat) begin
                q_reg <= Q_TEN;
            end else begin
                q_reg <= '0;
            end
        end
        if (cmd.div_step) begin
            rem_reg   <= dge ? ddiff[VAL_W-1:0] : dtrial[VAL_W-1:0];
            dbits_reg <= {dbits_reg[DIV_STEPS-2:0], 1'b0};
            q_reg     <= {q_reg[SEV_W-2:0], dge};
        end
        if (cmd.publish) begin
            otrig_reg  <= fired_reg;
            oid_reg    <= fired_reg ? next_id_reg : '0;
            okind_reg  <= fired_reg ? kind_reg    : '0;
            odet_reg   <= fired_reg ? detail_reg  : '0;
            osev_reg   <= fired_reg ? q_reg       : '0;
            oval_reg   <= fired_reg ? sel_val_reg : '0;
            olim_reg   <= fired_reg ? sel_lim_reg : '0;
            ophase_reg <= fired_reg ? phase_reg   : '0;
            otime_reg  <= fired_reg ? time_reg    : '0;
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_triggered = otrig_reg;
    assign out_event_id  = oid_reg;
    assign out_kind      = okind_reg;
    assign out_detail    = odet_reg;
    assign out_severity  = osev_reg;
    assign out_value     = oval_reg;
    assign out_limit     = olim_reg;
    assign out_phase     = ophase_reg;
    assign out_time      = otime_reg;

    a_sev_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg |-> (osev_reg <= Q_TEN))
        else $error("severity above clamp");

    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !otrig_reg) |-> (oid_reg == '0 && osev_reg == '0 && otime_reg == '0))
        else $error("no-event result carries data");

    a_id_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.publish && fired_reg) |=> (next_id_reg == $past(next_id_reg) + 1'b1))
        else $error("event id did not advance");

    a_id_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.publish && !fired_reg) |=> $stable(next_id_reg))
        else $error("event id moved without event");

endmodule

[src/power_quality_event_trigger_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_quality_event_trigger_unit
// Power-quality event trigger: one result per snapshot of six readings.
// ----------------------------------------------------------------------------
// One snapshot is taken in the idle state; the block then checks one channel
// per cycle through a shared threshold comparator, in priority order, and
// stops at the first channel that fires. A firing channel runs a 20-step
// restoring divider for severity, one quotient bit per cycle. The divider
// is skipped when the limit is not positive or severity clamps, and a
// snapshot with no event is published once all six channels are checked.
// The result sits in an output register, so the next snapshot is accepted
// while it waits to be taken. Limits are written through the cfg port,
// which is always ready; writes to indexes 6 and 7 are dropped.
// ----------------------------------------------------------------------------
module power_quality_event_trigger_unit
    import pqet_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // voltage_dev_value, voltage_thd_value, current_thd_value, unbalance_value,
    // freq_dev_value, xfmr_load_value, phase_tag, snapshot_time, zero pad
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_id, event_kind, detail_code, severity, trigger_value,
    // trigger_limit, event_phase, event_time, zero pad
    output logic [159:0] m_tdata,
    // triggered
    output logic         m_tuser
);

    dp_cmd_t                 cmd;
    dp_status_t              st;
    logic signed [VAL_W-1:0] in_val [NUM_CH];
    logic [VAL_W-1:0]        ev_id, ev_time;
    logic [KIND_W-1:0]       ev_kind;
    logic [DETAIL_W-1:0]     ev_detail;
    logic [SEV_W-1:0]        ev_sev;
    logic signed [VAL_W-1:0] ev_val, ev_lim;
    logic [PHASE_W-1:0]      ev_phase;

    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            in_val[i] = s_tdata[i*VAL_W +: VAL_W];
        end
    end

    pqet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pqet_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_val        (in_val),
        .in_phase      (s_tdata[193:192]),
        .in_time       (s_tdata[225:194]),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_triggered (m_tuser),
        .out_event_id  (ev_id),
        .out_kind      (ev_kind),
        .out_detail    (ev_detail),
        .out_severity  (ev_sev),
        .out_value     (ev_val),
        .out_limit     (ev_lim),
        .out_phase     (ev_phase),
        .out_time      (ev_time)
    );

    assign m_tdata = {3'b000, ev_time, ev_phase, ev_lim, ev_val, ev_sev,
                      ev_detail, ev_kind, ev_id};

endmodule
